### design/gicp_pkg.sv
// ----------------------------------------------------------------------------
// gicp_pkg
// Shared types, field widths and codes for the increasing chain partition core.
// ----------------------------------------------------------------------------
package gicp_pkg;

	// default element capacity
	localparam int MAX_ELEMENTS_DEF = 1024;

	// fixed field widths
	localparam int OP_W  = 2;
	localparam int VAL_W = 11;
	localparam int ST_W  = 2;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam int CNT_W = 11;

	// opcodes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_PLACE = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_UNLOADED = 2'd3;

	// chain length saturation point
	localparam logic [LEN_W-1:0] LEN_CAP = 11'd2047;

	// result word
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] chain_index;
		logic             new_chain;
		logic [LEN_W-1:0] chain_length;
		logic [CNT_W-1:0] chain_count;
		logic [VAL_W-1:0] element;
	} res_t;

	// controller to datapath commands, one phase active at a time
	typedef struct packed {
		logic take;
		logic decode;
		logic order;
		logic search;
		logic fetch;
		logic emit;
	} cmd_t;

	// next step requested by the datapath
	typedef enum logic [1:0] {
		STEP_EMIT,
		STEP_ORDER,
		STEP_SEARCH,
		STEP_FETCH
	} step_t;

	// datapath to controller status
	typedef struct packed {
		step_t next;
		logic  out_free;
	} sts_t;

endpackage

### design/gicp_in_if.sv
// ----------------------------------------------------------------------------
// gicp_in_if
// Input channel: one opcode and value word per handshake.
// ----------------------------------------------------------------------------
interface gicp_in_if import gicp_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [VAL_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);

endinterface

### design/gicp_out_if.sv
// ----------------------------------------------------------------------------
// gicp_out_if
// Output channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface gicp_out_if import gicp_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [IDX_W-1:0] chain_index;
	logic             new_chain;
	logic [LEN_W-1:0] chain_length;
	logic [CNT_W-1:0] chain_count;
	logic [VAL_W-1:0] element;

	modport source (
		output valid, output status, output chain_index, output new_chain,
		output chain_length, output chain_count, output element, input ready
	);
	modport sink (
		input valid, input status, input chain_index, input new_chain,
		input chain_length, input chain_count, input element, output ready
	);

endinterface

### design/greedy_increasing_chain_partition_core.sv
// ----------------------------------------------------------------------------
// greedy_increasing_chain_partition_core
// Greedy split of a permutation into the fewest increasing chains.
// ----------------------------------------------------------------------------
// One word in gives one result word out. The core works on one word at a
// time and takes the next input word once the current result sits in the
// output register, even if that result is not yet taken. Clear, load and
// unused opcodes go from decode to emit. A place that fails its range or
// load check goes to emit after decode or after the load-order check. A
// successful place does the load-order check and k binary search steps over
// the chain tails, at most ceil(log2(chains + 1)), then a fetch when it joins
// a chain; the search makes one read of the chain tail memory per cycle.
// Clear is constant time: an element counts as loaded only when its stored
// rank is below the load count and the load-order memory at that rank names
// it back, so no memory needs a clearing pass after reset.
// ----------------------------------------------------------------------------
module greedy_increasing_chain_partition_core import gicp_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gicp_in_if.sink    in_ch,
	gicp_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;
	res_t out_res;
	logic out_valid;

	// sequencer
	gicp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, search and result registers
	gicp_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_value  (in_ch.value),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_res   (out_res)
	);

	// channel hookup
	assign in_ch.ready         = cmd.take;
	assign out_ch.valid        = out_valid;
	assign out_ch.status       = out_res.status;
	assign out_ch.chain_index  = out_res.chain_index;
	assign out_ch.new_chain    = out_res.new_chain;
	assign out_ch.chain_length = out_res.chain_length;
	assign out_ch.chain_count  = out_res.chain_count;
	assign out_ch.element      = out_res.element;

endmodule

### design/gicp_ram.sv
// ----------------------------------------------------------------------------
// gicp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gicp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/gicp_datapath.sv
// ----------------------------------------------------------------------------
// gicp_datapath
// Rank and load-order stores, chain tail/length store, binary search over
// the chain tails, counters and the result and output registers.
// ----------------------------------------------------------------------------
module gicp_datapath import gicp_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic             in_valid,
	input  logic [OP_W-1:0]  in_opcode,
	input  logic [VAL_W-1:0] in_value,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_res
);

	localparam int AW  = $clog2(MAX_ELEMENTS);
	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int CHW = AW + LEN_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

	// item registers
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    rank_q;

	// counters and search bounds
	logic [CW-1:0] load_total_q, load_total_d;
	logic [CW-1:0] chain_total_q, chain_total_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0] mid_q, mid_d;

	// result and output registers
	res_t res_q, res_d;
	logic res_we;
	res_t out_q;
	logic out_valid_q;

	// memory ports
	logic           rank_we, order_we, chain_we;
	logic [AW-1:0]  rank_rdata, order_rdata;
	logic [CHW-1:0] chain_rdata, chain_wdata;
	logic [AW-1:0]  chain_waddr, chain_raddr;

	// decoded values
	logic           accept;
	logic [31:0]    e_in_w, e_q_w;
	logic [AW-1:0]  e_in, e_q;
	logic           val_bad;
	logic           loaded;
	logic [AW-1:0]  rd_tail;
	logic [LEN_W-1:0] rd_len, len_inc;
	logic           tail_lt;
	logic [CW-1:0]  lo_n, hi_n;
	logic [CW:0]    mid_sum;
	logic [AW-1:0]  mid_n, mid0;
	logic           search_end;
	logic [CW-1:0]  chain_total_inc;
	logic           do_new;
	step_t          step;
	res_t           res_base;

	assign accept = cmd.take && in_valid;

	// element index from the one-based value
	assign e_in_w = 32'(in_value) - 32'd1;
	assign e_in   = e_in_w[AW-1:0];
	assign e_q_w  = 32'(val_q) - 32'd1;
	assign e_q    = e_q_w[AW-1:0];
	assign val_bad = (val_q == '0) || (32'(val_q) > 32'(MAX_ELEMENTS));

	// loaded since clear: rank is below the load count and points back here
	assign loaded = (CW'(rank_q) < load_total_q) && (order_rdata == e_q);

	// binary search step: find the first chain whose tail is below the rank
	assign rd_tail    = chain_rdata[CHW-1:LEN_W];
	assign rd_len     = chain_rdata[LEN_W-1:0];
	assign tail_lt    = rd_tail < rank_q;
	assign lo_n       = tail_lt ? lo_q : CW'(mid_q) + 1'b1;
	assign hi_n       = tail_lt ? CW'(mid_q) : hi_q;
	assign mid_sum    = (CW+1)'(lo_n) + (CW+1)'(hi_n);
	assign mid_n      = AW'(mid_sum >> 1);
	assign search_end = lo_n == hi_n;
	assign mid0       = AW'(chain_total_q >> 1);

	assign len_inc         = (rd_len == LEN_CAP) ? rd_len : rd_len + 1'b1;
	assign chain_total_inc = chain_total_q + 1'b1;

	// phase logic
	always_comb begin
		step          = STEP_EMIT;
		res_base      = '0;
		res_base.status      = ST_OK;
		res_base.chain_count = CNT_W'(chain_total_q);
		res_d         = res_q;
		res_we        = 1'b0;
		rank_we       = 1'b0;
		order_we      = 1'b0;
		chain_we      = 1'b0;
		chain_waddr   = mid_q;
		chain_wdata   = {rank_q, len_inc};
		chain_raddr   = mid0;
		load_total_d  = load_total_q;
		chain_total_d = chain_total_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		mid_d         = mid_q;
		do_new        = 1'b0;

		if (cmd.decode) begin
			res_d = res_base;
			case (op_q)
				OP_CLEAR: begin
					load_total_d      = '0;
					chain_total_d     = '0;
					res_d.chain_count = '0;
					res_we            = 1'b1;
				end
				OP_LOAD: begin
					res_we = 1'b1;
					if (val_bad) begin
						res_d.status = ST_RANGE;
					end else if (load_total_q == MAX_CNT) begin
						res_d.status = ST_FULL;
					end else begin
						rank_we      = 1'b1;
						order_we     = 1'b1;
						load_total_d = load_total_q + 1'b1;
					end
				end
				OP_PLACE: begin
					res_d.element = val_q;
					if (val_bad) begin
						res_d.status = ST_RANGE;
						res_we       = 1'b1;
					end else begin
						step = STEP_ORDER;
					end
				end
				default: begin
					res_we = 1'b1;
				end
			endcase
		end

		if (cmd.order) begin
			res_d         = res_base;
			res_d.element = val_q;
			if (loaded) begin
				if (chain_total_q == '0) begin
					do_new = 1'b1;
				end else begin
					step        = STEP_SEARCH;
					lo_d        = '0;
					hi_d        = chain_total_q;
					mid_d       = mid0;
					chain_raddr = mid0;
				end
			end else begin
				res_d.status = ST_UNLOADED;
				res_we       = 1'b1;
			end
		end

		if (cmd.search) begin
			res_d         = res_base;
			res_d.element = val_q;
			lo_d          = lo_n;
			hi_d          = hi_n;
			if (!search_end) begin
				mid_d       = mid_n;
				chain_raddr = mid_n;
				step        = STEP_SEARCH;
			end else if (lo_n != chain_total_q) begin
				mid_d       = AW'(lo_n);
				chain_raddr = AW'(lo_n);
				step        = STEP_FETCH;
			end else begin
				do_new = 1'b1;
			end
		end

		// append to an existing chain
		if (cmd.fetch) begin
			chain_we           = 1'b1;
			chain_waddr        = mid_q;
			chain_wdata        = {rank_q, len_inc};
			res_d              = res_base;
			res_d.element      = val_q;
			res_d.chain_index  = IDX_W'(mid_q);
			res_d.chain_length = len_inc;
			res_we             = 1'b1;
		end

		// open a new chain after the last one
		if (do_new) begin
			res_we = 1'b1;
			if (chain_total_q == MAX_CNT) begin
				res_d.status = ST_FULL;
			end else begin
				chain_we           = 1'b1;
				chain_waddr        = AW'(chain_total_q);
				chain_wdata        = {rank_q, LEN_W'(1)};
				chain_total_d      = chain_total_inc;
				res_d.chain_index  = IDX_W'(chain_total_q);
				res_d.new_chain    = 1'b1;
				res_d.chain_length = LEN_W'(1);
				res_d.chain_count  = CNT_W'(chain_total_inc);
			end
		end
	end

	assign sts.next     = step;
	assign sts.out_free = !out_valid_q || out_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_total_q  <= '0;
			chain_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			load_total_q  <= load_total_d;
			chain_total_q <= chain_total_d;
			if (cmd.emit && sts.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_opcode;
			val_q <= in_value;
		end
		if (cmd.decode) begin
			rank_q <= rank_rdata;
		end
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		if (res_we) begin
			res_q <= res_d;
		end
		if (cmd.emit && sts.out_free) begin
			out_q <= res_q;
		end
	end

	// rank of each element, written in load order
	gicp_ram #(.WIDTH(AW), .DEPTH(MAX_ELEMENTS)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (e_q),
		.wdata (AW'(load_total_q)),
		.raddr (e_in),
		.rdata (rank_rdata)
	);

	// element loaded at each rank, checks the rank store back
	gicp_ram #(.WIDTH(AW), .DEPTH(MAX_ELEMENTS)) u_order_ram (
		.clk   (clk),
		.we    (order_we),
		.waddr (AW'(load_total_q)),
		.wdata (e_q),
		.raddr (rank_rdata),
		.rdata (order_rdata)
	);

	// tail rank and length of each chain
	gicp_ram #(.WIDTH(CHW), .DEPTH(MAX_ELEMENTS)) u_chain_ram (
		.clk   (clk),
		.we    (chain_we),
		.waddr (chain_waddr),
		.wdata (chain_wdata),
		.raddr (chain_raddr),
		.rdata (chain_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

### design/gicp_ctrl.sv
// ----------------------------------------------------------------------------
// gicp_ctrl
// Sequencer: accept, decode, load-order check, tail search, fetch, emit.
// ----------------------------------------------------------------------------
module gicp_ctrl import gicp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ORDER,
		S_SEARCH,
		S_FETCH,
		S_EMIT
	} state_t;

	state_t state_q, state_d;
	cmd_t   cmd_q;

	// command word for each state
	function automatic cmd_t cmd_of(state_t s);
		cmd_t c;
		c = '0;
		unique case (s)
			S_IDLE:   c.take   = 1'b1;
			S_DECODE: c.decode = 1'b1;
			S_ORDER:  c.order  = 1'b1;
			S_SEARCH: c.search = 1'b1;
			S_FETCH:  c.fetch  = 1'b1;
			S_EMIT:   c.emit   = 1'b1;
			default:  c.take   = 1'b1;
		endcase
		return c;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = (sts.next == STEP_ORDER) ? S_ORDER : S_EMIT;
			end
			S_ORDER: begin
				state_d = (sts.next == STEP_SEARCH) ? S_SEARCH : S_EMIT;
			end
			S_SEARCH: begin
				if (sts.next == STEP_SEARCH) begin
					state_d = S_SEARCH;
				end else if (sts.next == STEP_FETCH) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_FETCH: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= cmd_of(S_IDLE);
		end else begin
			state_q <= state_d;
			cmd_q   <= cmd_of(state_d);
		end
	end

	assign cmd = cmd_q;

endmodule
